@@ sv/rvwd_pkg.sv @@
// package: shared types and constants of the ramped volume wet/dry mixer
`timescale 1ns / 1ps

package rvwd_pkg;

    // sample and volume width
    localparam int SAMPLE_W = 16;
    // envelope fraction accumulator width
    localparam int FRAC_W = 16;
    // per-sample ramp step width (ramp / 8)
    localparam int STEP_W = 29;
    // ramp register width
    localparam int RAMP_W = 32;

    // configuration register indexes
    localparam logic [2:0] REG_START_LEFT   = 3'd0;
    localparam logic [2:0] REG_RAMP_LEFT    = 3'd1;
    localparam logic [2:0] REG_TARGET_LEFT  = 3'd2;
    localparam logic [2:0] REG_RAMP_RIGHT   = 3'd3;
    localparam logic [2:0] REG_TARGET_RIGHT = 3'd4;
    localparam logic [2:0] REG_WET_GAIN     = 3'd5;
    localparam logic [2:0] REG_DRY_GAIN     = 3'd6;

    // control from the sequencer to one envelope channel
    typedef struct packed {
        logic load;
        logic adv;
    } env_ctl_t;

endpackage

@@ sv/rvwd_env.sv @@
// module: one volume envelope channel with fraction accumulator and target clamp
`timescale 1ns / 1ps

module rvwd_env
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  rvwd_pkg::env_ctl_t                         ctl,
    input  logic signed [rvwd_pkg::SAMPLE_W-1:0]       start_volume,
    input  logic signed [rvwd_pkg::RAMP_W-1:0]         ramp,
    input  logic signed [rvwd_pkg::SAMPLE_W-1:0]       target,
    output logic signed [rvwd_pkg::SAMPLE_W-1:0]       volume
);

    localparam int SUM_W = rvwd_pkg::STEP_W + 1;
    localparam int CARRY_W = SUM_W - rvwd_pkg::FRAC_W;
    localparam int VSUM_W = rvwd_pkg::SAMPLE_W + 1;

    logic        [rvwd_pkg::FRAC_W-1:0]   frac_reg, frac_next;
    logic signed [rvwd_pkg::SAMPLE_W-1:0] vol_reg, vol_next;
    logic signed [rvwd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                                 rising_reg, rising_next;
    logic signed [rvwd_pkg::SAMPLE_W-1:0] target_reg, target_next;

    logic signed [rvwd_pkg::RAMP_W-1:0]   ramp_adj;
    logic signed [rvwd_pkg::RAMP_W-1:0]   ramp_div;
    logic        [rvwd_pkg::FRAC_W-1:0]   frac_cur;
    logic signed [rvwd_pkg::SAMPLE_W-1:0] vol_cur;
    logic signed [SUM_W-1:0]              sum;
    logic signed [CARRY_W-1:0]            carry;
    logic signed [VSUM_W-1:0]             vsum;
    logic signed [VSUM_W-1:0]             tgt_ext;
    logic signed [VSUM_W-1:0]             vclamp;

    // ramp / 8 truncated toward zero: bias negative values before the shift
    always_comb
    begin
        ramp_adj = ramp[rvwd_pkg::RAMP_W-1] ? (ramp + 32'sd7) : ramp;
        ramp_div = ramp_adj >>> 3;
    end

    // block start selects configuration values in place of the held state
    always_comb
    begin
        if (ctl.load)
        begin
            frac_cur    = '0;
            vol_cur     = start_volume;
            step_next   = ramp_div[rvwd_pkg::STEP_W-1:0];
            rising_next = ~ramp[rvwd_pkg::RAMP_W-1];
            target_next = target;
        end
        else
        begin
            frac_cur    = frac_reg;
            vol_cur     = vol_reg;
            step_next   = step_reg;
            rising_next = rising_reg;
            target_next = target_reg;
        end
    end

    // fraction plus step, carry into volume, clamp at target
    always_comb
    begin
        sum       = $signed({{(SUM_W-rvwd_pkg::FRAC_W){1'b0}}, frac_cur})
                  + {step_next[rvwd_pkg::STEP_W-1], step_next};
        carry     = sum[SUM_W-1:rvwd_pkg::FRAC_W];
        frac_next = sum[rvwd_pkg::FRAC_W-1:0];
        vsum      = {vol_cur[rvwd_pkg::SAMPLE_W-1], vol_cur}
                  + {{(VSUM_W-CARRY_W){carry[CARRY_W-1]}}, carry};
        tgt_ext   = {target_next[rvwd_pkg::SAMPLE_W-1], target_next};
        if (rising_next)
        begin
            vclamp = (vsum > tgt_ext) ? tgt_ext : vsum;
        end
        else
        begin
            vclamp = (vsum < tgt_ext) ? tgt_ext : vsum;
        end
        vol_next = vclamp[rvwd_pkg::SAMPLE_W-1:0];
    end

    // envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg   <= '0;
            vol_reg    <= '0;
            step_reg   <= '0;
            rising_reg <= 1'b0;
            target_reg <= '0;
        end
        else if (ctl.adv)
        begin
            frac_reg   <= frac_next;
            vol_reg    <= vol_next;
            step_reg   <= step_next;
            rising_reg <= rising_next;
            target_reg <= target_next;
        end
    end

    assign volume = vol_reg;

endmodule

@@ sv/ramped_volume_wet_dry_mixer_core.sv @@
// module: top level of the ramped volume wet/dry mixer with one shared multiplier
// sequencing: an item is accepted only in the idle state; eight 17x17 products and a final mix
// step, which waits for the output register, follow before the next item can be accepted
// reset: asynchronous, active low; clears configuration, envelope and snapshots
// to zero and empties the output register
`timescale 1ns / 1ps

module ramped_volume_wet_dry_mixer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // in_sample, dry_left_in, dry_right_in, wet_left_in, wet_right_in,
    // start_right_volume (16 bits each, lowest first)
    input  logic [95:0] s_axis_tdata,
    // block_start
    input  logic [0:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dry_left_out, dry_right_out, wet_left_out, wet_right_out,
    // left_volume_now, right_volume_now (16 bits each, lowest first)
    output logic [95:0] m_axis_tdata
);

    localparam int SW = rvwd_pkg::SAMPLE_W;
    localparam int MW = SW + 1;
    localparam int PW = 2 * MW;
    localparam int RW = SW + 2;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MUL  = 1'b1;

    localparam logic [3:0] STEP_LAST = 4'd8;
    localparam logic signed [PW-1:0] ROUND_Q15 = 34'sh4000;

    // configuration registers
    logic signed [SW-1:0] start_left_reg;
    logic signed [31:0]   ramp_left_reg;
    logic signed [SW-1:0] target_left_reg;
    logic signed [31:0]   ramp_right_reg;
    logic signed [SW-1:0] target_right_reg;
    logic signed [SW-1:0] wet_gain_reg;
    logic signed [SW-1:0] dry_gain_reg;

    // gain snapshots
    logic signed [SW-1:0] wet_snap_reg;
    logic signed [SW-1:0] dry_snap_reg;

    // sequencer
    logic       state_reg;
    logic [3:0] step_reg;
    logic       in_fire;
    logic       out_free;
    logic       mul_en;
    logic [2:0] post_idx;

    // item data
    logic signed [SW-1:0] smp_reg;
    logic signed [SW-1:0] mix_reg [4];
    logic signed [MW-1:0] g_reg [4];
    logic signed [SW-1:0] res_reg [3];

    // shared multiplier
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] rnd_sum;
    logic signed [RW-1:0] rnd;
    logic signed [RW-1:0] mixed;
    logic signed [SW-1:0] mixed_sat;

    // envelopes
    rvwd_pkg::env_ctl_t   env_ctl;
    logic signed [SW-1:0] lvol;
    logic signed [SW-1:0] rvol;

    logic        out_valid_reg;
    logic [95:0] out_data_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign mul_en        = (state_reg == ST_MUL) && (step_reg != STEP_LAST);
    assign post_idx      = 3'(step_reg - 4'd1);

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_left_reg   <= '0;
            ramp_left_reg    <= '0;
            target_left_reg  <= '0;
            ramp_right_reg   <= '0;
            target_right_reg <= '0;
            wet_gain_reg     <= '0;
            dry_gain_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rvwd_pkg::REG_START_LEFT:   start_left_reg   <= cfg_data[SW-1:0];
                rvwd_pkg::REG_RAMP_LEFT:    ramp_left_reg    <= cfg_data;
                rvwd_pkg::REG_TARGET_LEFT:  target_left_reg  <= cfg_data[SW-1:0];
                rvwd_pkg::REG_RAMP_RIGHT:   ramp_right_reg   <= cfg_data;
                rvwd_pkg::REG_TARGET_RIGHT: target_right_reg <= cfg_data[SW-1:0];
                rvwd_pkg::REG_WET_GAIN:     wet_gain_reg     <= cfg_data[SW-1:0];
                rvwd_pkg::REG_DRY_GAIN:     dry_gain_reg     <= cfg_data[SW-1:0];
                default:                    ;
            endcase
        end
    end

    // gain snapshots on block start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_snap_reg <= '0;
            dry_snap_reg <= '0;
        end
        else if (in_fire && s_axis_tuser[0])
        begin
            wet_snap_reg <= wet_gain_reg;
            dry_snap_reg <= dry_gain_reg;
        end
    end

    // envelopes advance in the accepting cycle
    assign env_ctl.load = in_fire && s_axis_tuser[0];
    assign env_ctl.adv  = in_fire;

    rvwd_env u_env_left
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (env_ctl),
        .start_volume (start_left_reg),
        .ramp         (ramp_left_reg),
        .target       (target_left_reg),
        .volume       (lvol)
    );

    rvwd_env u_env_right
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (env_ctl),
        .start_volume (s_axis_tdata[95:80]),
        .ramp         (ramp_right_reg),
        .target       (target_right_reg),
        .volume       (rvol)
    );

    // sequencer: eight multiplier steps per item, then a mix step that waits for the output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            smp_reg    <= s_axis_tdata[15:0];
            mix_reg[0] <= s_axis_tdata[31:16];
            mix_reg[1] <= s_axis_tdata[47:32];
            mix_reg[2] <= s_axis_tdata[63:48];
            mix_reg[3] <= s_axis_tdata[79:64];
        end
    end

    // operand select: steps 0-3 gain times volume, steps 4-7 sample times product
    always_comb
    begin
        if (step_reg[2])
        begin
            mul_a = {smp_reg[SW-1], smp_reg};
            mul_b = g_reg[step_reg[1:0]];
        end
        else
        begin
            mul_a = step_reg[1] ? {wet_snap_reg[SW-1], wet_snap_reg}
                                : {dry_snap_reg[SW-1], dry_snap_reg};
            mul_b = step_reg[0] ? {rvol[SW-1], rvol} : {lvol[SW-1], lvol};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // q15 rounding of the registered product, then mix and saturate
    always_comb
    begin
        rnd_sum = prod_reg + ROUND_Q15;
        rnd     = rnd_sum[RW+14:15];
        mixed   = {{2{mix_reg[post_idx[1:0]][SW-1]}}, mix_reg[post_idx[1:0]]} + rnd;
        if (mixed > 18'sd32767)
        begin
            mixed_sat = 16'sh7FFF;
        end
        else if (mixed < -18'sd32768)
        begin
            mixed_sat = 16'sh8000;
        end
        else
        begin
            mixed_sat = mixed[SW-1:0];
        end
    end

    // post-processing of the previous step's product
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_MUL) && (step_reg != 4'd0) && (step_reg != STEP_LAST))
        begin
            if (!post_idx[2])
            begin
                g_reg[post_idx[1:0]] <= rnd[MW-1:0];
            end
            else
            begin
                res_reg[post_idx[1:0]] <= mixed_sat;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_MUL) && (step_reg == STEP_LAST) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_MUL) && (step_reg == STEP_LAST) && out_free)
        begin
            out_data_reg <= {rvol, lvol, mixed_sat, res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
